// File: rtl/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg: shared constants for the request retry tracker
// Field widths, operation and event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package rrt_pkg;

    // Payload widths
    localparam int XID_W  = 32;
    localparam int PORT_W = 16;
    localparam int ATT_W  = 4;
    localparam int KIND_W = 3;
    localparam int OP_W   = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_XID    = 1'd1;

    localparam logic [ATT_W-1:0] MAX_ATTEMPTS_RST = 4'd3;
    localparam logic [XID_W-1:0] FIRST_XID_RST   = 32'd1;

    // Table depth default
    localparam int MAX_PENDING_DEF = 16;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CALL  = 2'd0;
    localparam logic [OP_W-1:0] OP_REPLY = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd2;
    localparam logic [OP_W-1:0] OP_ABORT = 2'd3;

    // Result event codes
    localparam logic [KIND_W-1:0] KIND_ISSUED    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REFUSED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COMPLETED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RESEND    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT   = 3'd4;

endpackage

// File: rtl/request_retry_tracker.sv
// ----------------------------------------------------------------------------
// request_retry_tracker: outstanding request transaction table
// Slot contents live in a synchronous memory; valid bits in flip-flops.
// ----------------------------------------------------------------------------
// A call is accepted, then, once the output register is free, the lowest free
// slot is written and the issued (or refused) result is registered. A reply,
// a retry tick and an abort walk the table through the single memory read
// port: each slot visited is read, then checked (and written back when it is
// resent), and only slots that are occupied are visited. A reply walks until
// the matching slot is retired or no occupied slot is left. A tick makes three
// walks (check limits, resend, time out); an abort makes one walk. A result
// that is ready waits while the output register is still held. A new
// transaction is taken only when the previous one has finished, while the
// last result may still wait in the output register. There is no clearing
// pass after reset.
module request_retry_tracker #(
    parameter int MAX_PENDING = rrt_pkg::MAX_PENDING_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration writes
    input  logic                             cfg_we,
    input  logic [rrt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rrt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // Input transactions
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [rrt_pkg::OP_W-1:0]         op,
    input  logic [rrt_pkg::PORT_W-1:0]       dest_port,
    input  logic [rrt_pkg::XID_W-1:0]        reply_xid,
    // Result transactions
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rrt_pkg::KIND_W-1:0]       kind,
    output logic [rrt_pkg::XID_W-1:0]        xid,
    output logic [rrt_pkg::PORT_W-1:0]       port,
    output logic [rrt_pkg::ATT_W-1:0]        attempt,
    output logic                             last
);
    import rrt_pkg::*;

    localparam int IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam logic [MAX_PENDING-1:0] ONE_VEC = {{(MAX_PENDING-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic [XID_W-1:0]  xid;
        logic [PORT_W-1:0] port;
        logic [ATT_W-1:0]  att;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALL,
        S_SEL,
        S_PROC
    } state_t;

    typedef enum logic [1:0] {
        P_MATCH,
        P_SCAN,
        P_RESEND,
        P_EXPIRE
    } pass_t;

    // Control and status registers
    state_t                 state_reg;
    pass_t                  pass_reg;
    logic [MAX_PENDING-1:0] valid_reg;
    logic [MAX_PENDING-1:0] todo_reg;
    logic [MAX_PENDING-1:0] exh_reg;
    logic [IDX_W-1:0]       cur_reg;
    logic [ATT_W-1:0]       max_att_reg;
    logic [XID_W-1:0]       next_xid_reg;

    // Captured input transaction
    logic [PORT_W-1:0]      port_reg;
    logic [XID_W-1:0]       rxid_reg;

    // Output register
    logic                   out_valid_reg;
    logic [KIND_W-1:0]      kind_reg;
    logic [XID_W-1:0]       xid_reg;
    logic [PORT_W-1:0]      port_out_reg;
    logic [ATT_W-1:0]       att_reg;
    logic                   last_reg;

    // Slot memory and its registered read data
    entry_t                 mem [MAX_PENDING];
    entry_t                 rd_reg;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    entry_t                 mem_wdata;
    logic                   mem_re;

    logic [IDX_W-1:0]       pick_idx;
    logic [IDX_W-1:0]       free_idx;
    logic                   full;
    logic                   out_free;
    logic [MAX_PENDING-1:0] cur_vec;
    logic [MAX_PENDING-1:0] rest;
    logic [ATT_W-1:0]       att_inc;

    // Lowest pending slot of the current walk and lowest free slot
    always_comb
    begin
        pick_idx = '0;
        free_idx = '0;
        for (int i = MAX_PENDING - 1; i >= 0; i--)
        begin
            if (todo_reg[i])
            begin
                pick_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign full     = &valid_reg;
    assign out_free = !out_valid_reg || out_ready;
    assign cur_vec  = ONE_VEC << cur_reg;
    assign rest     = todo_reg & ~cur_vec;
    assign att_inc  = rd_reg.att + ATT_W'(1);
    assign in_ready = (state_reg == S_IDLE);

    // Memory access decode
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg;
        mem_wdata = '{xid: rd_reg.xid, port: rd_reg.port, att: att_inc};
        if (state_reg == S_CALL)
        begin
            mem_we    = out_free && !full;
            mem_waddr = free_idx;
            mem_wdata = '{xid: next_xid_reg, port: port_reg, att: ATT_W'(1)};
        end
        else if (state_reg == S_PROC && pass_reg == P_RESEND)
        begin
            mem_we = out_free;
        end
        mem_re = (state_reg == S_SEL) && (todo_reg != '0);
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[pick_idx];
        end
    end

    // Sequencer, table flags and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= P_MATCH;
            valid_reg     <= '0;
            todo_reg      <= '0;
            exh_reg       <= '0;
            cur_reg       <= '0;
            max_att_reg   <= MAX_ATTEMPTS_RST;
            next_xid_reg  <= FIRST_XID_RST;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_ISSUED;
            xid_reg       <= '0;
            port_out_reg  <= '0;
            att_reg       <= '0;
            last_reg      <= 1'b0;
            port_reg      <= '0;
            rxid_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // Configuration writes must arrive only while the table is idle; the block itself does not enforce this
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAX_ATTEMPTS: max_att_reg  <= cfg_wdata[ATT_W-1:0];
                    CFG_FIRST_XID:    next_xid_reg <= cfg_wdata[XID_W-1:0];
                    default:          ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        port_reg <= dest_port;
                        rxid_reg <= reply_xid;
                        todo_reg <= valid_reg;
                        exh_reg  <= '0;
                        case (op)
                            OP_CALL:  state_reg <= S_CALL;
                            OP_REPLY:
                            begin
                                pass_reg  <= P_MATCH;
                                state_reg <= S_SEL;
                            end
                            OP_TICK:
                            begin
                                pass_reg  <= P_SCAN;
                                state_reg <= S_SEL;
                            end
                            default:
                            begin
                                // Abort: every occupied slot times out
                                exh_reg   <= valid_reg;
                                pass_reg  <= P_EXPIRE;
                                state_reg <= S_SEL;
                            end
                        endcase
                    end
                end

                S_CALL:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        port_out_reg  <= port_reg;
                        last_reg      <= 1'b1;
                        if (full)
                        begin
                            kind_reg <= KIND_REFUSED;
                            xid_reg  <= '0;
                            att_reg  <= '0;
                        end
                        else
                        begin
                            kind_reg            <= KIND_ISSUED;
                            xid_reg             <= next_xid_reg;
                            att_reg             <= ATT_W'(1);
                            valid_reg[free_idx] <= 1'b1;
                            next_xid_reg        <= next_xid_reg + XID_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end

                S_SEL:
                begin
                    if (todo_reg != '0)
                    begin
                        cur_reg   <= pick_idx;
                        state_reg <= S_PROC;
                    end
                    else
                    begin
                        // Current walk finished: move to the next one
                        unique case (pass_reg)
                            P_SCAN:
                            begin
                                todo_reg <= valid_reg & ~exh_reg;
                                pass_reg <= P_RESEND;
                            end
                            P_RESEND:
                            begin
                                todo_reg <= exh_reg;
                                pass_reg <= P_EXPIRE;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end

                S_PROC:
                begin
                    unique case (pass_reg)
                        P_MATCH:
                        begin
                            if (rd_reg.xid == rxid_reg)
                            begin
                                if (out_free)
                                begin
                                    out_valid_reg      <= 1'b1;
                                    kind_reg           <= KIND_COMPLETED;
                                    xid_reg            <= rd_reg.xid;
                                    port_out_reg       <= rd_reg.port;
                                    att_reg            <= rd_reg.att;
                                    last_reg           <= 1'b1;
                                    valid_reg[cur_reg] <= 1'b0;
                                    state_reg          <= S_IDLE;
                                end
                            end
                            else
                            begin
                                todo_reg  <= rest;
                                state_reg <= S_SEL;
                            end
                        end

                        P_SCAN:
                        begin
                            if (rd_reg.att >= max_att_reg)
                            begin
                                exh_reg[cur_reg] <= 1'b1;
                            end
                            todo_reg  <= rest;
                            state_reg <= S_SEL;
                        end

                        P_RESEND:
                        begin
                            if (out_free)
                            begin
                                out_valid_reg <= 1'b1;
                                kind_reg      <= KIND_RESEND;
                                xid_reg       <= rd_reg.xid;
                                port_out_reg  <= rd_reg.port;
                                att_reg       <= att_inc;
                                last_reg      <= (rest == '0) && (exh_reg == '0);
                                todo_reg      <= rest;
                                state_reg     <= S_SEL;
                            end
                        end

                        default:
                        begin
                            if (out_free)
                            begin
                                out_valid_reg      <= 1'b1;
                                kind_reg           <= KIND_TIMEOUT;
                                xid_reg            <= rd_reg.xid;
                                port_out_reg       <= rd_reg.port;
                                att_reg            <= rd_reg.att;
                                last_reg           <= (rest == '0);
                                valid_reg[cur_reg] <= 1'b0;
                                exh_reg[cur_reg]   <= 1'b0;
                                todo_reg           <= rest;
                                state_reg          <= S_SEL;
                            end
                        end
                    endcase
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign xid       = xid_reg;
    assign port      = port_out_reg;
    assign attempt   = att_reg;
    assign last      = last_reg;

    // A walk only ever visits occupied slots.
    a_todo_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEL || state_reg == S_PROC) |-> ((todo_reg & ~valid_reg) == '0))
        else $error("walk holds a slot that is not occupied");

    // Slots marked for timeout are still occupied until they are removed.
    a_exh_occupied: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEL || state_reg == S_PROC) |-> ((exh_reg & ~valid_reg) == '0))
        else $error("timeout mark on a free slot");

    // A write-back during a walk targets an occupied slot.
    a_writeback_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_PROC) |-> valid_reg[cur_reg])
        else $error("write-back to a free slot");

    // An issued call occupies a slot that was free before.
    a_call_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALL && mem_we) |=> valid_reg[$past(free_idx)]
            && !$past(valid_reg[free_idx]))
        else $error("call written into an occupied slot");

endmodule

// File: bench/request_retry_tracker_test.sv
// ----------------------------------------------------------------------------
// request_retry_tracker_test: self-checking bench for the retry tracker
// Drives calls, replies, retry ticks and aborts through the valid/ready input
// channel, predicts every result from a behavioural copy of the slot table,
// and compares each accepted result transaction with the oldest prediction.
// A short table of opening steps is followed by randomised phases, each under
// its own register settings, with random idling on both channels and one long
// hold-off on the result side.
// ----------------------------------------------------------------------------
module request_retry_tracker_test;

    import rrt_pkg::*;

    localparam int SLOTS          = MAX_PENDING_DEF;
    localparam int DRAIN_CYCLES   = 120;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 40;
    localparam int PLAN_ROWS      = 13;

    // One result transaction as it appears on the output ports.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [XID_W-1:0]  xid;
        logic [PORT_W-1:0] port;
        logic [ATT_W-1:0]  attempt;
        logic              last;
    } event_t;

    // One row of the opening plan; a row may be repeated several times.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [PORT_W-1:0] port;
        logic [XID_W-1:0]  rxid;
        logic [4:0]        reps;
        logic              typed;
        event_t            want;
    } plan_row_t;

    // How the id counter is treated at the start of a phase.
    typedef enum logic [1:0] {
        ID_KEEP,
        ID_LOAD,
        ID_REUSE
    } id_mode_t;

    localparam event_t NO_EVENT = '0;

    // Ports of the block
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  in_valid;
    logic                  in_ready;
    logic [OP_W-1:0]       op;
    logic [PORT_W-1:0]     dest_port;
    logic [XID_W-1:0]      reply_xid;
    logic                  out_valid;
    logic                  out_ready;
    logic [KIND_W-1:0]     kind;
    logic [XID_W-1:0]      xid;
    logic [PORT_W-1:0]     port;
    logic [ATT_W-1:0]      attempt;
    logic                  last;

    // Behavioural copy of the slot table and its registers
    logic                  slot_live  [SLOTS];
    logic [XID_W-1:0]      slot_id    [SLOTS];
    logic [PORT_W-1:0]     slot_dport [SLOTS];
    logic [ATT_W-1:0]      slot_tries [SLOTS];
    logic [ATT_W-1:0]      attempt_limit;
    logic [XID_W-1:0]      next_id;

    // Results caused by the latest transaction, and those still awaited
    event_t                step_events [SLOTS];
    int                    step_count;
    event_t                awaited_events [$];

    // Run control and statistics
    logic                  gaps_on;
    logic                  hold_req;
    int                    mismatch_count;
    int                    results_checked;
    int                    ops_sent   [4];
    int                    kinds_seen [8];

    plan_row_t             opening_plan [PLAN_ROWS];

    logic [ATT_W-1:0]      phase_limit [PHASES] = '{4'd0, 4'd15, 4'd1, 4'd3,
                                                    4'd15, 4'd2, 4'd7, 4'd3};
    id_mode_t              phase_ids   [PHASES] = '{ID_LOAD, ID_KEEP, ID_LOAD, ID_REUSE,
                                                    ID_KEEP, ID_LOAD, ID_REUSE, ID_LOAD};
    logic [XID_W-1:0]      phase_first [PHASES] = '{32'hFFFF_FFFE, 32'd0, 32'd0, 32'd0,
                                                    32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF};

    request_retry_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .dest_port (dest_port),
        .reply_xid (reply_xid),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .xid       (xid),
        .port      (port),
        .attempt   (attempt),
        .last      (last)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Record a failure; only the first few are described in full.
    task automatic report_failure(input string msg);
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("%s", msg);
            end
        end
    endtask

    // Append one predicted result for the current transaction.
    task automatic record_event(input logic [KIND_W-1:0] k, input logic [XID_W-1:0] id,
                                input logic [PORT_W-1:0] p, input logic [ATT_W-1:0] a);
        begin
            step_events[step_count] = '{k, id, p, a, 1'b0};
            step_count++;
        end
    endtask

    // Put the table copy back into its state after reset.
    task automatic clear_table;
        int i;
        begin
            for (i = 0; i < SLOTS; i++)
            begin
                slot_live[i]  = 1'b0;
                slot_id[i]    = '0;
                slot_dport[i] = '0;
                slot_tries[i] = '0;
            end
            attempt_limit = MAX_ATTEMPTS_RST;
            next_id       = FIRST_XID_RST;
        end
    endtask

    // Apply one accepted transaction to the table copy and work out its results.
    task automatic track_transaction(input logic [OP_W-1:0] t_op,
                                     input logic [PORT_W-1:0] t_port,
                                     input logic [XID_W-1:0] t_rxid);
        int   i;
        int   free_slot;
        logic matched;
        logic exhausted [SLOTS];
        begin
            step_count = 0;
            case (t_op)
                OP_CALL:
                begin
                    free_slot = -1;
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (!slot_live[i] && free_slot < 0)
                        begin
                            free_slot = i;
                        end
                    end
                    if (free_slot < 0)
                    begin
                        record_event(KIND_REFUSED, '0, t_port, '0);
                    end
                    else
                    begin
                        slot_live[free_slot]  = 1'b1;
                        slot_id[free_slot]    = next_id;
                        slot_dport[free_slot] = t_port;
                        slot_tries[free_slot] = 4'd1;
                        next_id               = next_id + 32'd1;
                        record_event(KIND_ISSUED, slot_id[free_slot], t_port, 4'd1);
                    end
                end
                OP_REPLY:
                begin
                    // Only the lowest slot holding the id is retired.
                    matched = 1'b0;
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (!matched && slot_live[i] && slot_id[i] == t_rxid)
                        begin
                            matched      = 1'b1;
                            slot_live[i] = 1'b0;
                            record_event(KIND_COMPLETED, slot_id[i], slot_dport[i],
                                         slot_tries[i]);
                        end
                    end
                end
                OP_TICK:
                begin
                    // The limit is judged on the counts held when the tick begins.
                    for (i = 0; i < SLOTS; i++)
                    begin
                        exhausted[i] = slot_live[i] && (slot_tries[i] >= attempt_limit);
                    end
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (slot_live[i] && !exhausted[i])
                        begin
                            slot_tries[i] = slot_tries[i] + 4'd1;
                            record_event(KIND_RESEND, slot_id[i], slot_dport[i],
                                         slot_tries[i]);
                        end
                    end
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (exhausted[i])
                        begin
                            slot_live[i] = 1'b0;
                            record_event(KIND_TIMEOUT, slot_id[i], slot_dport[i],
                                         slot_tries[i]);
                        end
                    end
                end
                default:
                begin
                    for (i = 0; i < SLOTS; i++)
                    begin
                        if (slot_live[i])
                        begin
                            slot_live[i] = 1'b0;
                            record_event(KIND_TIMEOUT, slot_id[i], slot_dport[i],
                                         slot_tries[i]);
                        end
                    end
                end
            endcase
            if (step_count > 0)
            begin
                step_events[step_count-1].last = 1'b1;
            end
        end
    endtask

    // Offer one input transaction, wait for it to be taken, then queue its results.
    // A row with a typed result stands in for the predicted one.
    task automatic send_request(input logic [OP_W-1:0] s_op, input logic [PORT_W-1:0] s_port,
                                input logic [XID_W-1:0] s_rxid, input logic typed,
                                input event_t want);
        int i;
        begin
            if (gaps_on && $urandom_range(99) < 29)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            in_valid  <= 1'b1;
            op        <= s_op;
            dest_port <= s_port;
            reply_xid <= s_rxid;
            do
            begin
                @(posedge clk);
            end
            while (!in_ready);
            track_transaction(s_op, s_port, s_rxid);
            ops_sent[s_op]++;
            if (typed)
            begin
                awaited_events.push_back(want);
            end
            else
            begin
                for (i = 0; i < step_count; i++)
                begin
                    awaited_events.push_back(step_events[i]);
                end
            end
        end
    endtask

    // Let all results drain, then give the block time to finish any table walk.
    task automatic wait_idle;
        begin
            while (awaited_events.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // Write one register; the copy takes the value at the same edge.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= value;
            @(posedge clk);
            if (idx == CFG_MAX_ATTEMPTS)
            begin
                attempt_limit = value[ATT_W-1:0];
            end
            else
            begin
                next_id = value;
            end
        end
    endtask

    // Pick a random transaction; most replies name an id that is outstanding.
    task automatic pick_request(output logic [OP_W-1:0] r_op, output logic [PORT_W-1:0] r_port,
                                output logic [XID_W-1:0] r_rxid);
        int r;
        int i;
        int live_slots [$];
        begin
            r      = $urandom_range(99);
            r_port = PORT_W'($urandom);
            r_rxid = $urandom;
            if (r < 45)
            begin
                r_op = OP_CALL;
            end
            else if (r < 75)
            begin
                r_op = OP_REPLY;
            end
            else if (r < 93)
            begin
                r_op = OP_TICK;
            end
            else
            begin
                r_op = OP_ABORT;
            end
            for (i = 0; i < SLOTS; i++)
            begin
                if (slot_live[i])
                begin
                    live_slots.push_back(i);
                end
            end
            if (r_op == OP_REPLY && live_slots.size() > 0 && $urandom_range(99) < 80)
            begin
                r_rxid = slot_id[live_slots[$urandom_range(live_slots.size() - 1)]];
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin : result_sink
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (gaps_on && $urandom_range(99) < 29)
            begin
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : result_check
        event_t seen;
        event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen = '{kind, xid, port, attempt, last};
            results_checked++;
            kinds_seen[kind]++;
            if (awaited_events.size() == 0)
            begin
                report_failure($sformatf({"Unexpected result: kind %0d xid %h port %h ",
                                          "attempt %0d last %0b"},
                                         kind, xid, port, attempt, last));
            end
            else
            begin
                want = awaited_events.pop_front();
                if (seen.kind !== want.kind || seen.xid !== want.xid ||
                    seen.port !== want.port || seen.attempt !== want.attempt ||
                    seen.last !== want.last)
                begin
                    report_failure($sformatf({"Result mismatch: expected kind %0d xid %h port %h ",
                                              "attempt %0d last %0b, got kind %0d xid %h port %h ",
                                              "attempt %0d last %0b"},
                                             want.kind, want.xid, want.port, want.attempt,
                                             want.last, seen.kind, seen.xid, seen.port,
                                             seen.attempt, seen.last));
                end
            end
        end
    end

    // Watchdog: give up when no transaction moves on either side for too long.
    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
            end
        end
        $display("Watchdog: no transaction for %0d cycles, %0d results still awaited",
                 WATCHDOG_LIMIT, awaited_events.size());
        $display("TB_ERROR");
        $finish;
    end

    // Main sequence: reset, opening plan, then randomised phases.
    initial
    begin : stimulus
        int            row;
        int            rep;
        int            ph;
        int            item;
        int            i;
        logic [XID_W-1:0]  reuse_id;
        logic [OP_W-1:0]   r_op;
        logic [PORT_W-1:0] r_port;
        logic [XID_W-1:0]  r_rxid;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_wdata       = '0;
        in_valid        = 1'b0;
        op              = OP_CALL;
        dest_port       = '0;
        reply_xid       = '0;
        gaps_on         = 1'b1;
        hold_req        = 1'b0;
        mismatch_count  = 0;
        results_checked = 0;
        ops_sent        = '{0, 0, 0, 0};
        kinds_seen      = '{0, 0, 0, 0, 0, 0, 0, 0};
        clear_table();

        // Opening plan, under the register values after reset. Empty-table tick
        // and abort, port extremes, a completion, unmatched replies at the id
        // extremes, resends up to the limit, a full table refusing a call, a
        // tick mixing resends with a timeout, and an abort of the fifteen slots left.
        opening_plan[0]  = '{OP_TICK,  16'h0000, 32'h0000_0000, 5'd1,  1'b0, NO_EVENT};
        opening_plan[1]  = '{OP_ABORT, 16'h0000, 32'h0000_0000, 5'd1,  1'b0, NO_EVENT};
        opening_plan[2]  = '{OP_CALL,  16'h0000, 32'h0000_0000, 5'd1,  1'b1,
                             '{KIND_ISSUED, 32'd1, 16'h0000, 4'd1, 1'b1}};
        opening_plan[3]  = '{OP_CALL,  16'hFFFF, 32'hFFFF_FFFF, 5'd1,  1'b1,
                             '{KIND_ISSUED, 32'd2, 16'hFFFF, 4'd1, 1'b1}};
        opening_plan[4]  = '{OP_REPLY, 16'h0000, 32'd1,         5'd1,  1'b1,
                             '{KIND_COMPLETED, 32'd1, 16'h0000, 4'd1, 1'b1}};
        opening_plan[5]  = '{OP_REPLY, 16'hFFFF, 32'hFFFF_FFFF, 5'd1,  1'b0, NO_EVENT};
        opening_plan[6]  = '{OP_REPLY, 16'h0000, 32'h0000_0000, 5'd1,  1'b0, NO_EVENT};
        opening_plan[7]  = '{OP_TICK,  16'h0000, 32'h0000_0000, 5'd1,  1'b1,
                             '{KIND_RESEND, 32'd2, 16'hFFFF, 4'd2, 1'b1}};
        opening_plan[8]  = '{OP_TICK,  16'h0000, 32'h0000_0000, 5'd1,  1'b1,
                             '{KIND_RESEND, 32'd2, 16'hFFFF, 4'd3, 1'b1}};
        opening_plan[9]  = '{OP_CALL,  16'h1234, 32'h0000_0000, 5'd15, 1'b0, NO_EVENT};
        opening_plan[10] = '{OP_CALL,  16'h5A5A, 32'h0000_0000, 5'd1,  1'b1,
                             '{KIND_REFUSED, 32'd0, 16'h5A5A, 4'd0, 1'b1}};
        opening_plan[11] = '{OP_TICK,  16'h0000, 32'h0000_0000, 5'd1,  1'b0, NO_EVENT};
        opening_plan[12] = '{OP_ABORT, 16'h0000, 32'h0000_0000, 5'd1,  1'b0, NO_EVENT};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < PLAN_ROWS; row++)
        begin
            for (rep = 0; rep < opening_plan[row].reps; rep++)
            begin
                send_request(opening_plan[row].op, opening_plan[row].port,
                             opening_plan[row].rxid, opening_plan[row].typed,
                             opening_plan[row].want);
            end
        end

        // Random phases; registers change only once the block has gone quiet.
        for (ph = 0; ph < PHASES; ph++)
        begin
            in_valid <= 1'b0;
            wait_idle();
            write_register(CFG_MAX_ATTEMPTS, {{(CFG_DATA_W-ATT_W){1'b0}}, phase_limit[ph]});
            if (phase_ids[ph] == ID_LOAD)
            begin
                write_register(CFG_FIRST_XID, (ph == 5) ? $urandom : phase_first[ph]);
            end
            else if (phase_ids[ph] == ID_REUSE)
            begin
                // Restart the counter on an outstanding id so that duplicates appear.
                reuse_id = $urandom;
                for (i = SLOTS - 1; i >= 0; i--)
                begin
                    if (slot_live[i])
                    begin
                        reuse_id = slot_id[i];
                    end
                end
                write_register(CFG_FIRST_XID, reuse_id);
            end
            cfg_we <= 1'b0;
            gaps_on = (ph != 5);
            if (ph == 4)
            begin
                hold_req = 1'b1;
            end
            for (item = 0; item < PHASE_ITEMS; item++)
            begin
                pick_request(r_op, r_port, r_rxid);
                send_request(r_op, r_port, r_rxid, 1'b0, NO_EVENT);
            end
        end

        in_valid <= 1'b0;
        wait_idle();
        if (awaited_events.size() != 0)
        begin
            report_failure($sformatf("%0d predicted results never arrived",
                                     awaited_events.size()));
        end

        $display("Summary: %0d requests (%0d call, %0d reply, %0d tick, %0d abort), %0d results",
                 ops_sent[OP_CALL] + ops_sent[OP_REPLY] + ops_sent[OP_TICK] + ops_sent[OP_ABORT],
                 ops_sent[OP_CALL], ops_sent[OP_REPLY], ops_sent[OP_TICK], ops_sent[OP_ABORT],
                 results_checked);
        $display({"Results by kind: %0d issued, %0d refused, %0d completed, ",
                  "%0d resend, %0d timeout"},
                 kinds_seen[KIND_ISSUED], kinds_seen[KIND_REFUSED], kinds_seen[KIND_COMPLETED],
                 kinds_seen[KIND_RESEND], kinds_seen[KIND_TIMEOUT]);
        if (mismatch_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("%0d failures found", mismatch_count);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: request_retry_tracker.f
rtl/rrt_pkg.sv
rtl/request_retry_tracker.sv
bench/request_retry_tracker_test.sv
